### rtl/lzssd_pkg.sv
// ---------------------------------------------------------------------------
// lzssd_pkg
// Types and constants shared by the stream decompressor modules.
// ---------------------------------------------------------------------------
package lzssd_pkg;

	localparam int HIST_DEPTH = 4096;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
	localparam int SIZE_W     = 29;
	localparam int CNT_W      = 5;

	localparam logic [7:0] MAGIC_0 = 8'h53;
	localparam logic [7:0] MAGIC_1 = 8'h53;
	localparam logic [7:0] MAGIC_2 = 8'h5A;
	localparam logic [7:0] MAGIC_3 = 8'h4C;
	localparam logic [7:0] DIST_HI_MASK = 8'hF0;
	localparam logic [7:0] LEN_MASK     = 8'h0F;
	localparam logic [CNT_W-1:0] LEN_BIAS = 5'd3;

	localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 29'(256 * 1024 * 1024);

	localparam logic REG_MAX_OUTPUT_SIZE = 1'b0;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
	localparam logic [2:0] ST_EARLY_END = 3'd2;
	localparam logic [2:0] ST_TOO_LARGE = 3'd3;
	localparam logic [2:0] ST_ZERO_DIST = 3'd4;
	localparam logic [2:0] ST_FAR_DIST  = 3'd5;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_SIZE,
		PH_FLAG,
		PH_LIT,
		PH_REF1,
		PH_REF2,
		PH_DONE,
		PH_ERR
	} phase_t;

	typedef enum logic [1:0] {
		CMD_EMPTY,
		CMD_LIT,
		CMD_COPY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         data;
		logic [HIST_AW-1:0] ref_dist;
		logic [CNT_W-1:0]   count;
		logic [HIST_AW-1:0] pos;
		logic               done;
		logic [2:0]         status;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} cmdq_stat_t;

endpackage

### rtl/lzss_stream_decompressor_unit.sv
// ---------------------------------------------------------------------------
// lzss_stream_decompressor_unit
// LZSS stream decompressor, 12-bit distance, 4-bit length, 4 KiB history.
// ---------------------------------------------------------------------------
// The compressed block enters one byte per transfer on the slave stream, with
// tlast on its final byte. The parser takes a byte each cycle while its
// two-entry command queue has room; the copy engine then loads each command
// and turns it into results at one per cycle while the result stream accepts
// them. A header, flag or reference-start byte and a literal each give one
// result, and a back reference gives one result for each of its n bytes copied
// (n up to 18), each copied byte read back from the history memory.
// Every input byte gives at least one result; the last result of a byte
// carries tlast, the done flag and the status code. The max_output_size
// register sits at address 0 of the APB port and should be written only
// while the block is idle.
module lzss_stream_decompressor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [8] done_res, [11:9] status
	output logic        m_axis_tlast,
	output logic [0:0]  m_axis_tuser,  // [0] byte_valid
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lzssd_pkg::*;

	logic [SIZE_W-1:0] max_size_q;
	cmd_t              cmd_in;
	cmd_t              cmd_head;
	cmdq_stat_t        q_stat;
	logic              push;
	logic              pop;
	logic [7:0]        out_byte;
	logic              done_res;
	logic [2:0]        status;
	logic              byte_valid;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_OUTPUT_SIZE) ? {3'b0, max_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= MAX_SIZE_RST;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_MAX_OUTPUT_SIZE) begin
			max_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	lzssd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.max_size (max_size_q),
		.q_full   (q_stat.full),
		.in_ready (s_axis_tready),
		.push     (push),
		.cmd      (cmd_in)
	);

	lzssd_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (cmd_in),
		.pop    (pop),
		.head   (cmd_head),
		.stat   (q_stat)
	);

	lzssd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (cmd_head),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (m_axis_tlast),
		.done_res   (done_res),
		.status     (status)
	);

	assign m_axis_tdata = {4'b0000, status, done_res, out_byte};
	assign m_axis_tuser = byte_valid;

endmodule

### rtl/lzssd_front.sv
// ---------------------------------------------------------------------------
// lzssd_front
// Header and token parser: turns each input byte into one back-end command.
// ---------------------------------------------------------------------------
module lzssd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [7:0]                 in_byte,
	input  logic                       in_last,
	input  logic [lzssd_pkg::SIZE_W-1:0] max_size,
	input  logic                       q_full,
	output logic                       in_ready,
	output logic                       push,
	output lzssd_pkg::cmd_t            cmd
);
	import lzssd_pkg::*;

	phase_t              phase_q, phase_n;
	logic [2:0]          hcnt_q, hcnt_n;
	logic [31:0]         expected_q, expected_n;
	logic [SIZE_W-1:0]   produced_q, produced_n;
	logic [7:0]          flag_q, flag_n;
	logic [3:0]          flags_q, flags_n;
	logic [7:0]          first_q, first_n;

	logic [31:0]         size_c;
	logic [31:0]         remain_c;
	logic [HIST_AW-1:0]  dist_c;
	logic [CNT_W-1:0]    len_c;
	logic                len_ge_rem;
	logic [CNT_W-1:0]    actual_c;
	logic [3:0]          flags_dec;
	logic [7:0]          flag_shift;
	phase_t              phase_item;
	logic [7:0]          magic_c;
	logic [2:0]          status_c;
	logic                done_c;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		case (hcnt_q[1:0])
			2'd0:    magic_c = MAGIC_0;
			2'd1:    magic_c = MAGIC_1;
			2'd2:    magic_c = MAGIC_2;
			default: magic_c = MAGIC_3;
		endcase
	end

	always_comb begin
		size_c     = expected_q | ({24'b0, in_byte} << {hcnt_q[1:0], 3'b000});
		remain_c   = expected_q - {3'b0, produced_q};
		dist_c     = {in_byte[7:4], first_q};
		len_c      = {1'b0, in_byte[3:0]} + LEN_BIAS;
		len_ge_rem = {27'b0, len_c} >= remain_c;
		actual_c   = len_ge_rem ? remain_c[CNT_W-1:0] : len_c;
		flags_dec  = flags_q - 4'd1;
		flag_shift = {flag_q[6:0], 1'b0};
		if (flags_dec == 4'd0) begin
			phase_item = PH_FLAG;
		end else if (flag_shift[7]) begin
			phase_item = PH_LIT;
		end else begin
			phase_item = PH_REF1;
		end

		phase_n    = phase_q;
		hcnt_n     = hcnt_q;
		expected_n = expected_q;
		produced_n = produced_q;
		flag_n     = flag_q;
		flags_n    = flags_q;
		first_n    = first_q;
		status_c   = ST_OK;
		done_c     = 1'b0;
		cmd          = '0;
		cmd.kind     = CMD_EMPTY;
		cmd.pos      = produced_q[HIST_AW-1:0];
		cmd.ref_dist = dist_c;

		case (phase_q)
			PH_MAGIC: begin
				if (in_byte != magic_c) begin
					status_c = ST_BAD_MAGIC;
					phase_n  = PH_ERR;
				end else if (hcnt_q == 3'd3) begin
					hcnt_n  = 3'd0;
					phase_n = PH_SIZE;
					if (in_last) status_c = ST_EARLY_END;
				end else begin
					hcnt_n = hcnt_q + 3'd1;
					if (in_last) status_c = ST_BAD_MAGIC;
				end
			end
			PH_SIZE: begin
				expected_n = size_c;
				if (hcnt_q == 3'd3) begin
					hcnt_n = 3'd0;
					if (size_c == 32'd0) begin
						done_c  = 1'b1;
						phase_n = PH_DONE;
					end else if (size_c > {3'b0, max_size}) begin
						status_c = ST_TOO_LARGE;
						phase_n  = PH_ERR;
					end else begin
						phase_n = PH_FLAG;
						if (in_last) status_c = ST_EARLY_END;
					end
				end else begin
					hcnt_n = hcnt_q + 3'd1;
					if (in_last) status_c = ST_EARLY_END;
				end
			end
			PH_FLAG: begin
				flag_n  = in_byte;
				flags_n = 4'd8;
				phase_n = in_byte[7] ? PH_LIT : PH_REF1;
				if (in_last) status_c = ST_EARLY_END;
			end
			PH_LIT: begin
				cmd.kind   = CMD_LIT;
				cmd.data   = in_byte;
				produced_n = produced_q + 1'b1;
				if (remain_c == 32'd1) begin
					done_c  = 1'b1;
					phase_n = PH_DONE;
				end else begin
					flag_n  = flag_shift;
					flags_n = flags_dec;
					phase_n = phase_item;
					if (in_last) status_c = ST_EARLY_END;
				end
			end
			PH_REF1: begin
				first_n = in_byte;
				phase_n = PH_REF2;
				if (in_last) status_c = ST_EARLY_END;
			end
			PH_REF2: begin
				if (dist_c == '0) begin
					status_c = ST_ZERO_DIST;
					phase_n  = PH_ERR;
				end else if ({17'b0, dist_c} > produced_q) begin
					status_c = ST_FAR_DIST;
					phase_n  = PH_ERR;
				end else begin
					cmd.kind   = CMD_COPY;
					cmd.count  = actual_c;
					produced_n = produced_q + {24'b0, actual_c};
					if (len_ge_rem) begin
						done_c  = 1'b1;
						phase_n = PH_DONE;
					end else begin
						flag_n  = flag_shift;
						flags_n = flags_dec;
						phase_n = phase_item;
						if (in_last) status_c = ST_EARLY_END;
					end
				end
			end
			default: begin
			end
		endcase

		cmd.done   = done_c;
		cmd.status = status_c;

		if (in_last) begin
			phase_n    = PH_MAGIC;
			hcnt_n     = 3'd0;
			expected_n = 32'd0;
			produced_n = '0;
			flag_n     = 8'd0;
			flags_n    = 4'd0;
			first_n    = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_MAGIC;
			hcnt_q     <= 3'd0;
			expected_q <= 32'd0;
			produced_q <= '0;
			flag_q     <= 8'd0;
			flags_q    <= 4'd0;
			first_q    <= 8'd0;
		end else if (push) begin
			phase_q    <= phase_n;
			hcnt_q     <= hcnt_n;
			expected_q <= expected_n;
			produced_q <= produced_n;
			flag_q     <= flag_n;
			flags_q    <= flags_n;
			first_q    <= first_n;
		end
	end

endmodule

### rtl/lzssd_cmd_fifo.sv
// ---------------------------------------------------------------------------
// lzssd_cmd_fifo
// Short command queue between parser and copy engine.
// ---------------------------------------------------------------------------
module lzssd_cmd_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  lzssd_pkg::cmd_t        cmd_in,
	input  logic                   pop,
	output lzssd_pkg::cmd_t        head,
	output lzssd_pkg::cmdq_stat_t  stat
);
	import lzssd_pkg::*;

	cmd_t               entries_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_q;
	logic [CMDQ_AW-1:0] rd_q;
	logic [CMDQ_CW-1:0] count_q;

	assign head       = entries_q[rd_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CMDQ_CW'(CMDQ_DEPTH));

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/lzssd_back.sv
// ---------------------------------------------------------------------------
// lzssd_back
// Copy engine: history memory, per-byte issue and the output stage.
// ---------------------------------------------------------------------------
module lzssd_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lzssd_pkg::cmd_t        head,
	input  lzssd_pkg::cmdq_stat_t  q_stat,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_byte,
	output logic                   byte_valid,
	output logic                   run_last,
	output logic                   done_res,
	output logic [2:0]             status
);
	import lzssd_pkg::*;

	logic [7:0]         hist_mem [HIST_DEPTH];

	logic               busy_q;
	cmd_t               cmd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [HIST_AW-1:0] rd_ptr_q;
	logic [HIST_AW-1:0] wr_ptr_q;

	logic               valid_s1;
	logic               bvalid_s1;
	logic               copy_s1;
	logic [7:0]         lit_s1;
	logic [HIST_AW-1:0] waddr_s1;
	logic               last_s1;
	logic               done_s1;
	logic [2:0]         status_s1;
	logic [7:0]         rdata_s1;
	logic               fwd_s1;
	logic [7:0]         fwd_data_s1;

	logic               advance;
	logic               issue;
	logic               wr_en;
	logic               final_elem;
	logic [7:0]         byte_s1;

	assign advance    = !valid_s1 || out_ready;
	assign issue      = busy_q && advance;
	assign pop        = !busy_q && !q_stat.empty;
	assign final_elem = (cnt_q == CNT_W'(1));
	assign wr_en      = valid_s1 && out_ready && bvalid_s1;

	assign byte_s1    = copy_s1 ? (fwd_s1 ? fwd_data_s1 : rdata_s1) : lit_s1;

	assign out_valid  = valid_s1;
	assign out_byte   = bvalid_s1 ? byte_s1 : 8'h00;
	assign byte_valid = bvalid_s1;
	assign run_last   = last_s1;
	assign done_res   = done_s1;
	assign status     = status_s1;

	always_ff @(posedge clk) begin
		if (wr_en) hist_mem[waddr_s1] <= byte_s1;
		if (issue) rdata_s1 <= hist_mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q    <= head;
			wr_ptr_q <= head.pos;
			rd_ptr_q <= head.pos - head.ref_dist;
		end else if (issue) begin
			wr_ptr_q <= wr_ptr_q + 1'b1;
			rd_ptr_q <= rd_ptr_q + 1'b1;
		end
		if (issue) begin
			bvalid_s1   <= (cmd_q.kind != CMD_EMPTY);
			copy_s1     <= (cmd_q.kind == CMD_COPY);
			lit_s1      <= cmd_q.data;
			waddr_s1    <= wr_ptr_q;
			last_s1     <= final_elem;
			done_s1     <= final_elem && cmd_q.done;
			status_s1   <= final_elem ? cmd_q.status : ST_OK;
			fwd_s1      <= wr_en && (waddr_s1 == rd_ptr_q);
			fwd_data_s1 <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= (head.kind == CMD_COPY) ? head.count : CNT_W'(1);
			end else if (issue) begin
				cnt_q <= cnt_q - 1'b1;
				if (final_elem) busy_q <= 1'b0;
			end
			if (advance) valid_s1 <= issue;
		end
	end

	a_load_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !busy_q)
		else $error("command loaded while a command is still running");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("running command with zero bytes left");

	a_last_ends_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && final_elem) |=> !busy_q && valid_s1 && last_s1)
		else $error("final byte did not close the command");

	a_copy_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cmd_q.kind == CMD_COPY) |-> cmd_q.ref_dist != '0)
		else $error("copy command with zero distance");

endmodule

### bench/lzss_stream_decompressor_unit_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzss_stream_decompressor_unit_checker
// Watches the compressed input stream, the result stream and the register
// port of the decompressor. Every accepted byte is decoded by its own parser
// and history copy into the results it must cause. Each result transfer is
// compared field by field against the oldest one still outstanding.
// ---------------------------------------------------------------------------
module lzss_stream_decompressor_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // [7:0] out_byte, [8] done_res, [11:9] status
	input  logic        m_axis_tlast,
	input  logic [0:0]  m_axis_tuser,  // [0] byte_valid
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending,
	output int          results_seen
);
	import lzssd_pkg::*;

	localparam logic [2:0] MAX_SIZE_ADDR = 3'(4 * REG_MAX_OUTPUT_SIZE);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       done_res;
		logic [2:0] status;
	} result_t;

	result_t           decoded_q[$];
	phase_t            phase;
	logic [2:0]        hdr_cnt;
	logic [31:0]       decl_size;
	logic [31:0]       made;
	logic [7:0]        flags;
	logic [3:0]        flags_left;
	logic [7:0]        ref_lo;
	logic [7:0]        hist [HIST_DEPTH];
	logic [SIZE_W-1:0] size_limit;

	function automatic void clear_parse();
		phase = PH_MAGIC;
		hdr_cnt = 3'd0;
		decl_size = 32'd0;
		made = 32'd0;
		flags = 8'd0;
		flags_left = 4'd0;
		ref_lo = 8'd0;
	endfunction

	function automatic void push_result(input logic [7:0] data, input logic valid);
		result_t r;
		r = '0;
		r.out_byte = data;
		r.byte_valid = valid;
		decoded_q = {decoded_q, r};
	endfunction

	// returns 1 once the declared size is reached, else moves on to the next flag bit
	function automatic logic end_item();
		if (made >= decl_size) begin
			phase = PH_DONE;
			return 1'b1;
		end
		flags = flags << 1;
		if (flags_left != 0)
			flags_left--;
		if (flags_left == 0)
			phase = PH_FLAG;
		else
			phase = flags[7] ? PH_LIT : PH_REF1;
		return 1'b0;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		logic [7:0]  magic;
		logic [2:0]  st;
		logic        fin;
		logic [11:0] ref_dist;
		logic [31:0] take;
		logic [7:0]  v;
		int          n0;
		result_t     tail;
		st = ST_OK;
		fin = 1'b0;
		magic = MAGIC_0;
		n0 = decoded_q.size();
		case (phase)
			PH_MAGIC: begin
				case (hdr_cnt[1:0])
					2'd0: magic = MAGIC_0;
					2'd1: magic = MAGIC_1;
					2'd2: magic = MAGIC_2;
					default: magic = MAGIC_3;
				endcase
				if (b != magic) begin
					st = ST_BAD_MAGIC;
					phase = PH_ERR;
				end else begin
					hdr_cnt++;
					if (hdr_cnt >= 4) begin
						hdr_cnt = 3'd0;
						phase = PH_SIZE;
						if (last)
							st = ST_EARLY_END;
					end else if (last) begin
						st = ST_BAD_MAGIC;
					end
				end
			end
			PH_SIZE: begin
				decl_size |= 32'(b) << (8 * hdr_cnt[1:0]);
				hdr_cnt++;
				if (hdr_cnt >= 4) begin
					hdr_cnt = 3'd0;
					if (decl_size == 0) begin
						fin = 1'b1;
						phase = PH_DONE;
					end else if (decl_size > 32'(size_limit)) begin
						st = ST_TOO_LARGE;
						phase = PH_ERR;
					end else begin
						phase = PH_FLAG;
						if (last)
							st = ST_EARLY_END;
					end
				end else if (last) begin
					st = ST_EARLY_END;
				end
			end
			PH_FLAG: begin
				flags = b;
				flags_left = 4'd8;
				phase = b[7] ? PH_LIT : PH_REF1;
				if (last)
					st = ST_EARLY_END;
			end
			PH_LIT: begin
				hist[made[11:0]] = b;
				push_result(b, 1'b1);
				made++;
				fin = end_item();
				if (!fin && last)
					st = ST_EARLY_END;
			end
			PH_REF1: begin
				ref_lo = b;
				phase = PH_REF2;
				if (last)
					st = ST_EARLY_END;
			end
			PH_REF2: begin
				ref_dist = {b[7:4], ref_lo};
				if (ref_dist == 0) begin
					st = ST_ZERO_DIST;
					phase = PH_ERR;
				end else if (32'(ref_dist) > made) begin
					st = ST_FAR_DIST;
					phase = PH_ERR;
				end else begin
					take = 32'(b[3:0]) + 32'd3;
					if (take > decl_size - made)
						take = decl_size - made;
					repeat (take) begin
						v = hist[12'(made - 32'(ref_dist))];
						hist[made[11:0]] = v;
						push_result(v, 1'b1);
						made++;
					end
					fin = end_item();
					if (!fin && last)
						st = ST_EARLY_END;
				end
			end
			default: ;
		endcase
		if (decoded_q.size() == n0)
			push_result(8'h00, 1'b0);
		tail = decoded_q.pop_back();
		tail.run_last = 1'b1;
		tail.done_res = fin;
		tail.status = st;
		decoded_q = {decoded_q, tail};
		if (last)
			clear_parse();
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t head;
		if (!arst_n) begin
			clear_parse();
			size_limit = MAX_SIZE_RST;
			decoded_q.delete();
			mismatches = 0;
			pending = 0;
			results_seen = 0;
		end else begin
			if (psel && penable && pready && paddr == MAX_SIZE_ADDR) begin
				if (pwrite)
					size_limit = pwdata[SIZE_W-1:0];
				else
					check_field("max_output_size", 32'(size_limit), prdata);
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (decoded_q.size() == 0) begin
					$error("result transfer with nothing outstanding: tdata %h tlast %b tuser %b",
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
					mismatches++;
				end else begin
					head = decoded_q.pop_front();
					check_field("out_byte", 32'(head.out_byte), 32'(m_axis_tdata[7:0]));
					check_field("byte_valid", 32'(head.byte_valid), 32'(m_axis_tuser[0]));
					check_field("run_last", 32'(head.run_last), 32'(m_axis_tlast));
					check_field("done_res", 32'(head.done_res), 32'(m_axis_tdata[8]));
					check_field("status", 32'(head.status), 32'(m_axis_tdata[11:9]));
				end
			end
			pending = decoded_q.size();
		end
	end

endmodule

### bench/lzss_stream_decompressor_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzss_stream_decompressor_unit_test
// Feeds the decompressor compressed blocks: a few hand-built ones for the
// header and end cases, then random blocks that are mostly well formed with
// some cut short, corrupted or pure noise, under several size limits and
// with random gaps on both streams. The checker beside the block predicts
// and compares; this module drives stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module lzss_stream_decompressor_unit_test;
	import lzssd_pkg::*;

	localparam logic [2:0] MAX_SIZE_ADDR = 3'(4 * REG_MAX_OUTPUT_SIZE);
	localparam int STALL_PCT   = 70;
	localparam int BOTH_PCT    = 27;
	localparam int HOLD_CYCLES = 400;

	typedef enum {
		BK_CLEAN,
		BK_TRAIL,
		BK_CUT,
		BK_BAD_MAGIC,
		BK_ZERO_DIST,
		BK_FAR_DIST,
		BK_NOISE,
		BK_HUGE
	} block_kind_t;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          pending;
	int          results_seen;

	idle_mode_t  idle_mode = IDLE_NONE;
	logic        hold_req = 1'b0;
	logic        hold_on = 1'b0;
	int unsigned cur_max = 32'(MAX_SIZE_RST);
	int unsigned sent = 0;
	int unsigned blocks = 0;
	int unsigned limits_used = 0;

	lzss_stream_decompressor_unit DUT (.*);

	lzss_stream_decompressor_unit_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_on)
			m_axis_tready <= 1'b0;
		else if (idle_mode == IDLE_RECV)
			m_axis_tready <= $urandom_range(99) >= STALL_PCT;
		else if (idle_mode == IDLE_BOTH)
			m_axis_tready <= $urandom_range(99) >= BOTH_PCT;
		else
			m_axis_tready <= 1'b1;
	end

	// long receiver hold-off while the sender keeps offering bytes
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL lzss_stream_decompressor_unit");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SEND) ? STALL_PCT : (idle_mode == IDLE_BOTH) ? BOTH_PCT : 0;
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic settle_output();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (24) @(posedge clk);
	endtask

	task automatic apb_transfer(input logic wr, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= MAX_SIZE_ADDR;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_limit(input int unsigned val);
		cur_max = val;
		apb_transfer(1'b1, val);
		@(posedge clk);
		apb_transfer(1'b0, 32'd0);
		limits_used++;
	endtask

	task automatic run_block(input block_kind_t kind, input int unsigned size,
			input int unsigned lit_pct, input int unsigned long_pct);
		logic [7:0]  bytes_q[$];
		logic [7:0]  item_q[$];
		logic [7:0]  flag;
		int unsigned made, ref_dist, len, reach, bit_i, items, fault_at, n;
		logic        stop;
		blocks++;
		if (kind == BK_NOISE) begin
			repeat ($urandom_range(1, 12)) bytes_q = {bytes_q, 8'($urandom)};
		end else begin
			bytes_q = {bytes_q, MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
			if (kind == BK_BAD_MAGIC) begin
				bit_i = $urandom_range(0, 3);
				bytes_q[bit_i] = bytes_q[bit_i] ^ 8'($urandom_range(1, 255));
			end
			for (bit_i = 0; bit_i < 4; bit_i++)
				bytes_q = {bytes_q, 8'(size >> (8 * bit_i))};
			stop = (kind == BK_BAD_MAGIC) || (kind == BK_HUGE) || (size > cur_max);
			made = 0;
			items = 0;
			fault_at = $urandom_range(0, 5);
			while (!stop && made < size) begin
				flag = 8'($urandom);
				item_q.delete();
				for (bit_i = 0; bit_i < 8 && !stop && made < size; bit_i++) begin
					if ((kind == BK_ZERO_DIST || kind == BK_FAR_DIST) && items == fault_at) begin
						flag[7 - bit_i] = 1'b0;
						ref_dist = (kind == BK_ZERO_DIST) ? 0 : $urandom_range(made + 1, 4095);
						item_q = {item_q, 8'(ref_dist)};
						item_q = {item_q, {4'(ref_dist >> 8), 4'($urandom)}};
						stop = 1'b1;
					end else if (made == 0 || $urandom_range(99) < lit_pct) begin
						flag[7 - bit_i] = 1'b1;
						item_q = {item_q, 8'($urandom)};
						made++;
					end else begin
						flag[7 - bit_i] = 1'b0;
						reach = (made > 4095) ? 4095 : made;
						ref_dist = ($urandom_range(1) != 0) ?
							$urandom_range(1, (reach < 4) ? reach : 4) : $urandom_range(1, reach);
						len = ($urandom_range(99) < long_pct) ? 18 : $urandom_range(3, 18);
						item_q = {item_q, 8'(ref_dist)};
						item_q = {item_q, {4'(ref_dist >> 8), 4'(len - 3)}};
						made += (len < size - made) ? len : size - made;
					end
					items++;
				end
				bytes_q = {bytes_q, flag};
				foreach (item_q[i])
					bytes_q = {bytes_q, item_q[i]};
			end
			if (kind == BK_TRAIL)
				n = $urandom_range(1, 4);
			else if (stop)
				n = $urandom_range(0, 6);
			else
				n = 0;
			repeat (n) bytes_q = {bytes_q, 8'($urandom)};
			if (kind == BK_CUT) begin
				n = $urandom_range(1, bytes_q.size() - 1);
				while (bytes_q.size() > n)
					bytes_q.delete(bytes_q.size() - 1);
			end
		end
		foreach (bytes_q[i])
			send_byte(bytes_q[i], i == bytes_q.size() - 1);
	endtask

	initial begin
		logic [8:0]  dir_q[$];
		int unsigned limits[5];
		int unsigned goal, size, pick;
		block_kind_t kind;
		// {tlast, byte}: bad magic, end inside magic, end on the fourth magic byte,
		// zero size, then a literal and a clipped overlapping copy with a trailing byte
		dir_q = '{9'h053, 9'h000, 9'h1FF,
			9'h153,
			9'h053, 9'h053, 9'h05A, 9'h14C,
			9'h053, 9'h053, 9'h05A, 9'h04C, 9'h000, 9'h000, 9'h000, 9'h100,
			9'h053, 9'h053, 9'h05A, 9'h04C, 9'h004, 9'h000, 9'h000, 9'h000,
			9'h080, 9'h000, 9'h001, 9'h00F, 9'h1FF};
		limits = '{40, 0, 268435456, $urandom_range(100, 3000), 5000};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_transfer(1'b0, 32'd0);
		foreach (dir_q[i])
			send_byte(dir_q[i][7:0], dir_q[i][8]);
		blocks += 5;
		settle_output();
		for (int p = 0; p < 5; p++) begin
			set_limit(limits[p]);
			if (p == 2) begin
				idle_mode <= IDLE_NONE;
				hold_req <= 1'b1;
				run_block(BK_CLEAN, 60, 50, 20);
			end
			if (p == 4) begin
				idle_mode <= idle_mode_t'($urandom_range(0, 3));
				run_block(BK_CLEAN, 4120, 0, 100);
			end
			goal = sent + ((limits[p] == 0) ? 10 : 20);
			while (sent < goal) begin
				idle_mode <= idle_mode_t'($urandom_range(0, 3));
				pick = $urandom_range(99);
				kind = (pick < 45) ? BK_CLEAN : (pick < 55) ? BK_TRAIL : (pick < 70) ? BK_CUT :
					(pick < 77) ? BK_ZERO_DIST : (pick < 84) ? BK_FAR_DIST :
					(pick < 89) ? BK_BAD_MAGIC : (pick < 95) ? BK_NOISE : BK_HUGE;
				pick = $urandom_range(19);
				size = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(41, 200) : $urandom_range(1, 40);
				if (kind == BK_HUGE)
					size = $urandom;
				run_block(kind, size, $urandom_range(20, 80), 20);
			end
			settle_output();
		end
		$display("covered %0d blocks, %0d compressed bytes in, %0d results out", blocks, sent,
			results_seen);
		$display("size limit set %0d times, from 0 up to the reset value", limits_used);
		if (mismatches == 0 && pending == 0)
			$display("PASS lzss_stream_decompressor_unit");
		else
			$display("FAIL lzss_stream_decompressor_unit");
		$finish;
	end

endmodule

### filelist.f
rtl/lzssd_pkg.sv
rtl/lzssd_front.sv
rtl/lzssd_cmd_fifo.sv
rtl/lzssd_back.sv
rtl/lzss_stream_decompressor_unit.sv
bench/lzss_stream_decompressor_unit_checker.sv
bench/lzss_stream_decompressor_unit_test.sv
